>>> rtl/core/jgsi_pkg.sv
// ----------------------------------------------------------------------------
// Joint goal step interpolator package
// Shared constants, register indexes and fixed-point helpers.
// ----------------------------------------------------------------------------
package jgsi_pkg;

  localparam int DEF_MAX_JOINTS    = 8;
  localparam int DEF_FRACTION_BITS = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int JC_W       = 4;
  localparam int STEP_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_JOINT_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SNAP_THRESHOLD = 2'd2;

  localparam logic [JC_W-1:0]   RST_JOINT_COUNT    = 4'd6;
  localparam logic [STEP_W-1:0] RST_STEP_LENGTH    = 16'd66;
  localparam logic [STEP_W-1:0] RST_SNAP_THRESHOLD = 16'd1311;

  // Pi with 32 fraction bits.
  localparam logic [63:0] PI_Q32 = 64'd13493037705;

  // Returns mult * pi rounded to nearest at fbits fraction bits.
  function automatic logic [63:0] scale_pi(input int mult, input int fbits);
    logic [63:0] p;
    p = 64'(mult) * PI_Q32;
    return (p + (64'd1 << (31 - fbits))) >> (32 - fbits);
  endfunction

endpackage

>>> rtl/core/joint_goal_step_interpolator_unit.sv
// ----------------------------------------------------------------------------
// Joint goal step interpolator
// Loads goal and current angle pairs, then emits one step command per joint.
// ----------------------------------------------------------------------------
// Usage: drive in_goal_angle and in_current_angle and raise start while busy
// is low; the pair is taken in that cycle. Each pair goes through a read, a
// wrap and a bit-serial square that is added to the error sum. The pair that
// completes a run adds a bit-serial square root of one result bit per cycle,
// then for each joint a read, a wrap, a serial multiply by step_length and a
// restoring divide by the norm. Commands appear on out_joint_command with
// out_valid high for one cycle each, in load order, with out_last_joint on
// the final one. The receiver cannot stall; busy drops in the cycle that
// shows the last command. The user must write registers through cfg_we,
// cfg_index and cfg_data only while busy is low; the block itself does not
// enforce this. Reset empties the run and restores register defaults.
// ----------------------------------------------------------------------------
module joint_goal_step_interpolator_unit #(
  parameter int MAX_JOINTS    = jgsi_pkg::DEF_MAX_JOINTS,
  parameter int FRACTION_BITS = jgsi_pkg::DEF_FRACTION_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [FRACTION_BITS+2:0]            in_goal_angle,
  input  logic [FRACTION_BITS+2:0]            in_current_angle,
  output logic                                out_valid,
  output logic signed [FRACTION_BITS+3:0]     out_joint_command,
  output logic                                out_last_joint,
  input  logic                                cfg_we,
  input  logic [jgsi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [jgsi_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import jgsi_pkg::*;

  localparam int AW      = FRACTION_BITS + 3;
  localparam int CMD_W   = FRACTION_BITS + 4;
  localparam int MAG_W   = FRACTION_BITS + 2;
  localparam int DW      = AW + 2;
  localparam int IDX_W   = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int CNT_W   = $clog2(MAX_JOINTS + 1);
  localparam int SUM_W   = 2 * MAG_W + $clog2(MAX_JOINTS);
  localparam int NORM_W  = (SUM_W + 1) / 2;
  localparam int SQ_W    = 2 * NORM_W;
  localparam int REM_W   = NORM_W + 2;
  localparam int MUL_W   = (MAG_W > STEP_W) ? MAG_W : STEP_W;
  localparam int ACC_W   = (SUM_W > MAG_W + STEP_W) ? SUM_W : MAG_W + STEP_W;
  localparam int MAXN    = (MUL_W > NORM_W) ? MUL_W : NORM_W;
  localparam int STC_W   = $clog2(MAXN + 1);
  localparam int EW      = (CNT_W > JC_W) ? CNT_W : JC_W;
  localparam int CMP_W   = MUL_W;
  localparam int CX_W    = ((CMD_W > STEP_W) ? CMD_W : STEP_W) + 1;

  localparam logic [STC_W-1:0] MUL_LAST  = STC_W'(MUL_W - 1);
  localparam logic [STC_W-1:0] SQRT_LAST = STC_W'(NORM_W - 1);
  localparam logic [STC_W-1:0] DIV_LAST  = STC_W'(STEP_W - 1);

  localparam logic signed [DW-1:0] PI_C       = DW'(scale_pi(1, FRACTION_BITS));
  localparam logic signed [DW-1:0] TWO_PI_C   = DW'(scale_pi(2, FRACTION_BITS));
  localparam logic signed [DW-1:0] THREE_PI_C = DW'(scale_pi(3, FRACTION_BITS));
  localparam logic signed [DW-1:0] OFF0 = THREE_PI_C - PI_C;
  localparam logic signed [DW-1:0] OFF1 = THREE_PI_C - TWO_PI_C - PI_C;
  localparam logic signed [DW-1:0] OFF2 = THREE_PI_C - TWO_PI_C - TWO_PI_C - PI_C;
  localparam logic signed [DW-1:0] TH1  = TWO_PI_C - THREE_PI_C;
  localparam logic signed [DW-1:0] TH2  = TWO_PI_C + TWO_PI_C - THREE_PI_C;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_WRAP = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_SQRT = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [STC_W-1:0]  step_r, step_nxt;
  logic              emit_r, emit_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [JC_W-1:0]   joint_count_r;
  logic [STEP_W-1:0] step_length_r;
  logic [STEP_W-1:0] snap_threshold_r;

  logic [AW-1:0]     goal_mem [MAX_JOINTS];
  logic [AW-1:0]     cur_mem  [MAX_JOINTS];
  logic [AW-1:0]     rd_goal_r;
  logic [AW-1:0]     rd_cur_r;

  logic [MAG_W-1:0]  mag_r;
  logic              neg_r;
  logic [ACC_W-1:0]  mcand_r;
  logic [MUL_W-1:0]  mplier_r;
  logic [ACC_W-1:0]  acc_r;
  logic [SQ_W-1:0]   rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [NORM_W-1:0] root_r;
  logic [NORM_W-1:0] norm_r;
  logic [NORM_W-1:0] drem_r;
  logic [STEP_W-1:0] dlow_r;
  logic [STEP_W-1:0] q_r;
  logic [CMD_W-1:0]  out_cmd_r;
  logic              out_last_r;

  logic signed [DW-1:0] diff;
  logic signed [DW-1:0] wrap_d;
  logic signed [DW-1:0] wrap_abs;
  logic [MAG_W-1:0]     wrap_mag;
  logic                 wrap_neg;
  logic [ACC_W-1:0]     acc_add;
  logic [REM_W+1:0]     rem_sh;
  logic [REM_W+1:0]     trial;
  logic                 sqrt_ge;
  logic [REM_W-1:0]     rem_new;
  logic [NORM_W-1:0]    root_new;
  logic [NORM_W:0]      div_trial;
  logic                 div_ge;
  logic [NORM_W-1:0]    drem_new;
  logic [EW-1:0]        jc_ext;
  logic [EW-1:0]        eff;
  logic                 run_done;
  logic [CNT_W-1:0]     idx_inc;
  logic                 last_j;
  logic [CX_W-1:0]      cur_x;
  logic [CX_W-1:0]      q_x;
  logic [CX_W-1:0]      step_cmd;
  logic                 snap;
  logic [CMD_W-1:0]     cmd_sel;

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_joint_command = out_cmd_r;
  assign out_last_joint    = out_last_r;

  // Wrap of goal minus current into [-pi, pi).
  assign diff = $signed(DW'(rd_goal_r)) - $signed(DW'(rd_cur_r));
  always_comb begin
    if (diff >= TH2) begin
      wrap_d = diff + OFF2;
    end else if (diff >= TH1) begin
      wrap_d = diff + OFF1;
    end else begin
      wrap_d = diff + OFF0;
    end
  end
  assign wrap_neg = wrap_d[DW-1];
  assign wrap_abs = wrap_neg ? -wrap_d : wrap_d;
  assign wrap_mag = wrap_abs[MAG_W-1:0];

  assign acc_add = acc_r + (mplier_r[0] ? mcand_r : '0);

  assign rem_sh   = {rem_r, rad_r[SQ_W-1:SQ_W-2]};
  assign trial    = (REM_W + 2)'({root_r, 2'b01});
  assign sqrt_ge  = (rem_sh >= trial);
  assign rem_new  = sqrt_ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
  assign root_new = {root_r[NORM_W-2:0], sqrt_ge};

  assign div_trial = {drem_r, dlow_r[STEP_W-1]};
  assign div_ge    = (div_trial >= {1'b0, norm_r});
  assign drem_new  = div_ge ? NORM_W'(div_trial - {1'b0, norm_r}) : NORM_W'(div_trial);

  always_comb begin
    jc_ext = EW'(joint_count_r);
    if (joint_count_r == '0) begin
      eff = EW'(1);
    end else if (jc_ext > EW'(MAX_JOINTS)) begin
      eff = EW'(MAX_JOINTS);
    end else begin
      eff = jc_ext;
    end
  end
  assign run_done = (EW'(cnt_r) >= eff);

  assign idx_inc = CNT_W'(idx_r) + CNT_W'(1);
  assign last_j  = (idx_inc == cnt_r);

  assign cur_x    = CX_W'(rd_cur_r);
  assign q_x      = CX_W'(q_r);
  assign step_cmd = neg_r ? (cur_x - q_x) : (cur_x + q_x);
  assign snap     = (CMP_W'(mag_r) < CMP_W'(snap_threshold_r));

  always_comb begin
    if (snap) begin
      cmd_sel = CMD_W'(rd_goal_r);
    end else if (norm_r == '0) begin
      cmd_sel = CMD_W'(rd_cur_r);
    end else begin
      cmd_sel = step_cmd[CMD_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    emit_nxt      = emit_r;
    sum_nxt       = sum_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_READ;
          idx_nxt   = cnt_r[IDX_W-1:0];
          cnt_nxt   = cnt_r + CNT_W'(1);
          emit_nxt  = 1'b0;
        end
      end
      S_READ: begin
        state_nxt = S_WRAP;
      end
      S_WRAP: begin
        state_nxt = S_MUL;
        step_nxt  = '0;
      end
      S_MUL: begin
        if (step_r == MUL_LAST) begin
          step_nxt = '0;
          if (emit_r) begin
            state_nxt = S_DIV;
          end else begin
            sum_nxt   = acc_add[SUM_W-1:0];
            state_nxt = run_done ? S_SQRT : S_IDLE;
          end
        end else begin
          step_nxt = step_r + STC_W'(1);
        end
      end
      S_SQRT: begin
        if (step_r == SQRT_LAST) begin
          step_nxt  = '0;
          idx_nxt   = '0;
          emit_nxt  = 1'b1;
          state_nxt = S_READ;
        end else begin
          step_nxt = step_r + STC_W'(1);
        end
      end
      S_DIV: begin
        if (step_r == DIV_LAST) begin
          step_nxt  = '0;
          state_nxt = S_OUT;
        end else begin
          step_nxt = step_r + STC_W'(1);
        end
      end
      S_OUT: begin
        out_valid_nxt = 1'b1;
        if (last_j) begin
          cnt_nxt   = '0;
          sum_nxt   = '0;
          emit_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      cnt_r            <= '0;
      idx_r            <= '0;
      step_r           <= '0;
      emit_r           <= 1'b0;
      sum_r            <= '0;
      out_valid_r      <= 1'b0;
      joint_count_r    <= RST_JOINT_COUNT;
      step_length_r    <= RST_STEP_LENGTH;
      snap_threshold_r <= RST_SNAP_THRESHOLD;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      step_r      <= step_nxt;
      emit_r      <= emit_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_JOINT_COUNT:    joint_count_r    <= cfg_data[JC_W-1:0];
          REG_STEP_LENGTH:    step_length_r    <= cfg_data[STEP_W-1:0];
          REG_SNAP_THRESHOLD: snap_threshold_r <= cfg_data[STEP_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      goal_mem[cnt_r[IDX_W-1:0]] <= in_goal_angle;
      cur_mem[cnt_r[IDX_W-1:0]]  <= in_current_angle;
    end
    if (state_r == S_READ) begin
      rd_goal_r <= goal_mem[idx_r];
      rd_cur_r  <= cur_mem[idx_r];
    end
    if (state_r == S_WRAP) begin
      mag_r    <= wrap_mag;
      neg_r    <= wrap_neg;
      mcand_r  <= ACC_W'(wrap_mag);
      mplier_r <= emit_r ? MUL_W'(step_length_r) : MUL_W'(wrap_mag);
      acc_r    <= emit_r ? '0 : ACC_W'(sum_r);
    end
    if (state_r == S_MUL) begin
      acc_r    <= acc_add;
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
      if (step_r == MUL_LAST) begin
        rad_r  <= SQ_W'(acc_add[SUM_W-1:0]);
        rem_r  <= '0;
        root_r <= '0;
        drem_r <= NORM_W'(acc_add >> STEP_W);
        dlow_r <= acc_add[STEP_W-1:0];
      end
    end
    if (state_r == S_SQRT) begin
      rad_r  <= rad_r << 2;
      rem_r  <= rem_new;
      root_r <= root_new;
      if (step_r == SQRT_LAST) begin
        norm_r <= root_new;
      end
    end
    if (state_r == S_DIV) begin
      drem_r <= drem_new;
      dlow_r <= dlow_r << 1;
      q_r    <= {q_r[STEP_W-2:0], div_ge};
    end
    if (state_r == S_OUT) begin
      out_cmd_r  <= cmd_sel;
      out_last_r <= last_j;
    end
  end

  a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start transfer");

  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result transfer without work in progress");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_joint) |-> !busy)
    else $error("block still busy after the last command");

  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_joint) |-> busy)
    else $error("run ended before its last command");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(cnt_r) <= CNT_W'(MAX_JOINTS))
    else $error("loaded pair count beyond storage");

endmodule

>>> tb/tb_joint_goal_step_interpolator_unit.sv
// ----------------------------------------------------------------------------
// Joint goal step interpolator testbench
// Loads goal and current angle pairs through the start/busy handshake and
// rewrites the registers between phases. A directed table covers the field
// extremes and the corner cases, and random phases follow it. An in-bench
// model predicts every joint command and its last-joint flag, and each
// command transfer is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_joint_goal_step_interpolator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import jgsi_pkg::*;

  localparam int      JOINT_SLOTS   = DEF_MAX_JOINTS;
  localparam longint  PI_FIX        = 205887;
  localparam longint  TWO_PI_FIX    = 411775;
  localparam longint  THREE_PI_FIX  = 617662;
  localparam int      RANDOM_PAIRS  = 245;
  localparam int      STEADY_PAIRS  = 40;
  localparam int      SETTLE_CYCLES = 40;
  localparam int      STALL_LIMIT   = 3000;

  typedef enum logic {ROW_WRITE, ROW_PAIR} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_index;
    logic [CFG_DATA_W-1:0]  data;
    logic [18:0]            goal;
    logic [18:0]            cur;
    logic                   typed;
    logic signed [19:0]     command;
  } stim_row_t;

  typedef struct packed {
    logic signed [19:0] command;
    logic               last;
  } joint_command_t;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [18:0]            in_goal_angle;
  logic [18:0]            in_current_angle;
  logic                   out_valid;
  logic signed [19:0]     out_joint_command;
  logic                   out_last_joint;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  logic [JC_W-1:0]        joint_count_reg  = RST_JOINT_COUNT;
  logic [STEP_W-1:0]      step_length_reg  = RST_STEP_LENGTH;
  logic [STEP_W-1:0]      snap_reg         = RST_SNAP_THRESHOLD;
  logic [18:0]            goal_hist [JOINT_SLOTS];
  logic [18:0]            cur_hist [JOINT_SLOTS];
  longint unsigned        error_energy     = 0;
  int                     loaded_joints    = 0;

  joint_command_t         pending_commands [$];
  int                     failures         = 0;
  int                     stall_cycles     = 0;

  joint_goal_step_interpolator_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_goal_angle     (in_goal_angle),
    .in_current_angle  (in_current_angle),
    .out_valid         (out_valid),
    .out_joint_command (out_joint_command),
    .out_last_joint    (out_last_joint),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint wrapped_error(input logic [18:0] g, input logic [18:0] c);
    longint x;
    longint r;
    x = longint'(g) - longint'(c) + THREE_PI_FIX;
    r = x % TWO_PI_FIX;
    if (r < 0) r += TWO_PI_FIX;
    return r - PI_FIX;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic int effective_joints(input logic [JC_W-1:0] jc);
    if (jc < 1) return 1;
    if (jc > JOINT_SLOTS) return JOINT_SLOTS;
    return int'(jc);
  endfunction

  // Stores one pair and, when the run is complete, queues one command per joint.
  task automatic compute_step_commands(input logic [18:0] g, input logic [18:0] c);
    longint          d;
    longint          mag;
    longint          q;
    longint          cmd;
    longint unsigned root;
    joint_command_t  item;
    if (loaded_joints >= JOINT_SLOTS) loaded_joints = 0;
    goal_hist[loaded_joints] = g;
    cur_hist[loaded_joints] = c;
    d = wrapped_error(g, c);
    mag = (d < 0) ? -d : d;
    error_energy += longint'(mag * mag);
    loaded_joints++;
    if (loaded_joints >= effective_joints(joint_count_reg)) begin
      root = floor_sqrt(error_energy);
      for (int k = 0; k < loaded_joints; k++) begin
        d = wrapped_error(goal_hist[k], cur_hist[k]);
        mag = (d < 0) ? -d : d;
        if (mag < longint'(snap_reg)) begin
          cmd = longint'(goal_hist[k]);
        end else if (root == 0) begin
          cmd = longint'(cur_hist[k]);
        end else begin
          q = longint'((longint'(mag) * longint'(step_length_reg)) / longint'(root));
          cmd = longint'(cur_hist[k]) + ((d < 0) ? -q : q);
        end
        item.command = cmd[19:0];
        item.last = (k == loaded_joints - 1);
        pending_commands.push_back(item);
      end
      loaded_joints = 0;
      error_energy = 0;
    end
  endtask

  // Lowers start, waits for every command and for the block to go idle, then settles.
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    do @(posedge clk); while (pending_commands.size() != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_JOINT_COUNT:    joint_count_reg = value[JC_W-1:0];
      REG_STEP_LENGTH:    step_length_reg = value;
      REG_SNAP_THRESHOLD: snap_reg = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_pair(input logic [18:0] g, input logic [18:0] c, input bit idle_ok);
    @(negedge clk);
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    start <= 1'b1;
    in_goal_angle <= g;
    in_current_angle <= c;
    do @(posedge clk); while (busy);
    compute_step_commands(g, c);
  endtask

  function automatic stim_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] value);
    return '{ROW_WRITE, idx, value, 19'd0, 19'd0, 1'b0, 20'sd0};
  endfunction

  function automatic stim_row_t pair_row(input logic [18:0] g, input logic [18:0] c);
    return '{ROW_PAIR, REG_JOINT_COUNT, 16'd0, g, c, 1'b0, 20'sd0};
  endfunction

  function automatic stim_row_t typed_row(input logic [18:0] g, input logic [18:0] c,
                                          input logic signed [19:0] cmd);
    return '{ROW_PAIR, REG_JOINT_COUNT, 16'd0, g, c, 1'b1, cmd};
  endfunction

  always @(posedge clk) begin : check_commands
    joint_command_t exp_cmd;
    if (rst_n && out_valid) begin
      if (pending_commands.size() == 0) begin
        $error("Command transfer with no prediction waiting: %0d", out_joint_command);
        failures++;
      end else begin
        exp_cmd = pending_commands.pop_front();
        if (out_joint_command !== exp_cmd.command) begin
          $error("out_joint_command: expected %0d, actual %0d",
                 exp_cmd.command, out_joint_command);
          failures++;
        end
        if (out_last_joint !== exp_cmd.last) begin
          $error("out_last_joint: expected %0d, actual %0d", exp_cmd.last, out_last_joint);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    stim_row_t   directed_plan [38];
    logic [18:0] g;
    logic [18:0] c;
    logic [15:0] jc_value;
    logic [15:0] step_value;
    logic [15:0] snap_value;
    int          sent;
    int          count;
    int          offset;

    rst_n = 1'b0;
    start = 1'b0;
    in_goal_angle = '0;
    in_current_angle = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;

    directed_plan = '{
      pair_row(19'd0, 19'd0),
      pair_row(19'd524287, 19'd0),
      pair_row(19'd0, 19'd524287),
      pair_row(19'd411774, 19'd0),
      pair_row(19'd205887, 19'd0),
      pair_row(19'd100000, 19'd300000),
      write_row(REG_JOINT_COUNT, 16'd1),
      typed_row(19'd1000, 19'd1000, 20'sd1000),
      typed_row(19'd411774, 19'd411774, 20'sd411774),
      write_row(REG_SNAP_THRESHOLD, 16'd0),
      pair_row(19'd5, 19'd7),
      typed_row(19'd1234, 19'd1234, 20'sd1234),
      write_row(REG_STEP_LENGTH, 16'd65535),
      write_row(REG_SNAP_THRESHOLD, 16'd65535),
      pair_row(19'd0, 19'd205887),
      write_row(REG_STEP_LENGTH, 16'd0),
      typed_row(19'd300000, 19'd100000, 20'sd100000),
      write_row(REG_JOINT_COUNT, 16'd0),
      typed_row(19'd42, 19'd42, 20'sd42),
      write_row(REG_JOINT_COUNT, 16'd15),
      write_row(REG_STEP_LENGTH, 16'd65535),
      write_row(REG_SNAP_THRESHOLD, 16'd0),
      pair_row(19'd212512, 19'd524287),
      pair_row(19'd0, 19'd0),
      pair_row(19'd524287, 19'd524287),
      pair_row(19'd1, 19'd0),
      pair_row(19'd0, 19'd1),
      pair_row(19'd411774, 19'd411774),
      pair_row(19'd205887, 19'd205887),
      pair_row(19'd65535, 19'd65536),
      write_row(REG_JOINT_COUNT, 16'd6),
      write_row(REG_STEP_LENGTH, 16'd66),
      write_row(REG_SNAP_THRESHOLD, 16'd1311),
      pair_row(19'd10000, 19'd20000),
      pair_row(19'd400000, 19'd3),
      pair_row(19'd3, 19'd400000),
      write_row(REG_JOINT_COUNT, 16'd2),
      pair_row(19'd205888, 19'd0)
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_WRITE) begin
        wait_idle();
        write_register(directed_plan[i].reg_index, directed_plan[i].data);
      end else begin
        send_pair(directed_plan[i].goal, directed_plan[i].cur, 1'b1);
        if (directed_plan[i].typed) begin
          pending_commands[$].command = directed_plan[i].command;
        end
      end
    end

    sent = 0;
    while (sent < RANDOM_PAIRS) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0:       jc_value = 16'd0;
        1:       jc_value = 16'($urandom_range(9, 15));
        default: jc_value = 16'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 5))
        0:       step_value = 16'd0;
        1:       step_value = 16'd65535;
        2:       step_value = 16'($urandom_range(0, 65535));
        default: step_value = 16'($urandom_range(1, 200));
      endcase
      case ($urandom_range(0, 5))
        0:       snap_value = 16'd0;
        1:       snap_value = 16'd65535;
        2:       snap_value = 16'($urandom_range(0, 65535));
        default: snap_value = 16'($urandom_range(0, 3000));
      endcase
      write_register(REG_JOINT_COUNT, jc_value);
      write_register(REG_STEP_LENGTH, step_value);
      write_register(REG_SNAP_THRESHOLD, snap_value);

      count = effective_joints(jc_value[JC_W-1:0]) * $urandom_range(1, 3);
      if ($urandom_range(0, 3) == 0) count += $urandom_range(1, 7);
      for (int i = 0; i < count; i++) begin
        c = 19'($urandom_range(0, 411774));
        case ($urandom_range(0, 9))
          5: begin
            g = 19'($urandom);
            c = 19'($urandom);
          end
          6: g = c;
          7: begin
            offset = $urandom_range(0, 2 * int'(snap_value) + 2) - int'(snap_value) - 1;
            g = 19'(int'(c) + offset);
          end
          8: begin
            g = ($urandom_range(0, 1) != 0) ? 19'd524287 : 19'd0;
            c = ($urandom_range(0, 1) != 0) ? 19'd411774 : 19'd205887;
          end
          9: g = 19'(int'(c) + $urandom_range(0, 200) - 100);
          default: g = 19'($urandom_range(0, 411774));
        endcase
        send_pair(g, c, sent < RANDOM_PAIRS - STEADY_PAIRS);
        sent++;
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_commands.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> joint_goal_step_interpolator_unit.f
rtl/core/jgsi_pkg.sv
rtl/core/joint_goal_step_interpolator_unit.sv
tb/tb_joint_goal_step_interpolator_unit.sv
